>>> sv/rau_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Opcode and status codes used by the core and its testbench.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_CMP = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;

endpackage

>>> sv/rau_divider.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit divider
// Restoring divider, one quotient bit per cycle, giving quotient and remainder.
// ----------------------------------------------------------------------------
module rau_divider #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quot,
	output logic [W-1:0] rem
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  q_q;
	logic [W-1:0]  r_q;
	logic [W-1:0]  d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W:0]    trial;
	logic [W:0]    diff;

	// One shift and subtract step of the long division.
	assign trial = {r_q, q_q[W-1]};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!diff[W]) begin
				r_q <= diff[W-1:0];
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= trial[W-1:0];
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end

	assign quot = q_q;
	assign rem  = r_q;

endmodule

>>> sv/rational_arith_unit_core.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit core
// Adds, subtracts, multiplies, divides or compares two fractions and reduces
// an arithmetic result by the greatest common divisor.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one item (opcode and two fractions) when in_valid
// is high and in_stall is low; in_stall stays high from that edge until the
// result item has been taken, so items are handled one at a time.
// The result item sits in output registers with out_valid until out_stall
// is low; a stalled result holds and no new item is taken meanwhile.
// Sequence after an item is accepted: error cases go straight to the output
// state; compare runs three sequenced multiplies and a combine step. An
// arithmetic item runs the same and then one Euclid step on the shared
// divider per remainder of the GCD (at most about 3*FIELD_BITS steps,
// usually far fewer), a step to close the GCD, two divisions by the GCD
// and one range check. The shared restoring divider gives one quotient bit
// per cycle, and each Euclid step or division holds the sequencer until the
// divider is done. Each taken result returns the sequencer to its idle
// state before the next item is taken.
// Reset clears the sequencer and the output valid; an item at work is dropped.
// ----------------------------------------------------------------------------
module rational_arith_unit_core
	import rau_pkg::*;
#(
	parameter int FIELD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [2:0]            opcode,
	input  logic [FIELD_BITS-1:0] a_num,
	input  logic [FIELD_BITS-2:0] a_den,
	input  logic [FIELD_BITS-1:0] b_num,
	input  logic [FIELD_BITS-2:0] b_den,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [FIELD_BITS-1:0] res_num,
	output logic [FIELD_BITS-2:0] res_den,
	output logic                  is_equal,
	output logic [1:0]            status
);

	localparam int N  = FIELD_BITS;
	localparam int W  = 2 * FIELD_BITS + 1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_M1   = 4'd1;
	localparam logic [3:0] S_M2   = 4'd2;
	localparam logic [3:0] S_COMB = 4'd3;
	localparam logic [3:0] S_GSTR = 4'd4;
	localparam logic [3:0] S_GWT  = 4'd5;
	localparam logic [3:0] S_D1S  = 4'd6;
	localparam logic [3:0] S_D1W  = 4'd7;
	localparam logic [3:0] S_D2S  = 4'd8;
	localparam logic [3:0] S_D2W  = 4'd9;
	localparam logic [3:0] S_FIN  = 4'd10;
	localparam logic [3:0] S_OUT  = 4'd11;
	localparam logic [3:0] S_M3   = 4'd12;

	logic [3:0]   state_q;
	logic [2:0]   op_q;
	logic         sa_q, sb_q, neg_q;
	logic [N-1:0] am_q, bm_q;
	logic [N-2:0] ad_q, bd_q;
	logic [W-1:0] t1_q, t2_q, t3_q, mag_q, den_q, gx_q, gy_q, g_q;
	logic [N-1:0] mul_a;
	logic [N-1:0] mul_b;
	logic [2*N-1:0] prod_raw;
	logic [W-1:0] prod;
	logic         dv_start;
	logic [W-1:0] dv_a, dv_b, dv_q, dv_r;
	logic         dv_done;
	logic [N-1:0] an_mag, bn_mag;

	assign an_mag = a_num[N-1] ? N'(-a_num) : a_num;
	assign bn_mag = b_num[N-1] ? N'(-b_num) : b_num;

	// Shared multiplier operands, chosen by sequencer state and opcode.
	always_comb begin
		mul_a = am_q;
		mul_b = {1'b0, bd_q};
		if (state_q == S_M2) begin
			mul_a = bm_q;
			mul_b = {1'b0, ad_q};
		end
		if (state_q == S_M1 && op_q == OP_MUL) mul_b = bm_q;
		if (state_q == S_M2 && op_q == OP_MUL) begin
			mul_a = {1'b0, ad_q};
			mul_b = {1'b0, bd_q};
		end
		if (state_q == S_M2 && op_q == OP_DIV) begin
			mul_a = {1'b0, ad_q};
			mul_b = bm_q;
		end
		// The third product is the common denominator of add and subtract.
		if (state_q == S_M3) begin
			mul_a = {1'b0, ad_q};
			mul_b = {1'b0, bd_q};
		end
	end
	assign prod_raw = mul_a * mul_b;
	assign prod     = {1'b0, prod_raw};

	// Shared divider for Euclid steps and the final reduction.
	always_comb begin
		dv_start = 1'b0;
		dv_a = gx_q;
		dv_b = gy_q;
		case (state_q)
			S_GSTR: dv_start = 1'b1;
			S_D1S: begin
				dv_start = 1'b1;
				dv_a = mag_q;
				dv_b = g_q;
			end
			S_D2S: begin
				dv_start = 1'b1;
				dv_a = den_q;
				dv_b = g_q;
			end
			default: dv_start = 1'b0;
		endcase
	end

	rau_divider #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .dividend(dv_a),
		.divisor(dv_b), .done(dv_done), .quot(dv_q), .rem(dv_r)
	);

	assign in_stall = (state_q != S_IDLE);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (opcode > OP_CMP || a_den == '0 || b_den == '0 ||
						    (opcode == OP_DIV && b_num == '0)) begin
							state_q <= S_OUT;
							out_valid <= 1'b1;
						end else begin
							state_q <= S_M1;
						end
					end
				end
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_COMB;
				S_COMB: begin
					if (op_q == OP_CMP) begin
						state_q <= S_OUT;
						out_valid <= 1'b1;
					end else begin
						state_q <= S_GSTR;
					end
				end
				S_GSTR: begin
					if (gy_q == '0) state_q <= S_D1S;
					else state_q <= S_GWT;
				end
				S_GWT: if (dv_done) state_q <= S_GSTR;
				S_D1S: state_q <= S_D1W;
				S_D1W: if (dv_done) state_q <= S_D2S;
				S_D2S: state_q <= S_D2W;
				S_D2W: if (dv_done) state_q <= S_FIN;
				S_FIN: begin
					state_q <= S_OUT;
					out_valid <= 1'b1;
				end
				S_OUT: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
						out_valid <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q <= opcode;
				sa_q <= a_num[N-1];
				sb_q <= b_num[N-1];
				am_q <= an_mag;
				bm_q <= bn_mag;
				ad_q <= a_den;
				bd_q <= b_den;
				res_num  <= '0;
				res_den  <= '0;
				is_equal <= 1'b0;
				status   <= ST_ERR;
			end
			S_M1: t1_q <= prod;
			S_M2: begin
				t2_q <= prod;
				if (op_q == OP_SUB && bm_q != '0) sb_q <= ~sb_q;
			end
			S_M3: t3_q <= prod;
			S_COMB: begin
				if (op_q == OP_CMP) begin
					res_num <= '0;
					res_den <= (N-1)'(1);
					status  <= ST_OK;
					is_equal <= (t1_q == t2_q) && ((sa_q == sb_q) || t1_q == '0);
				end else begin
					if (op_q == OP_MUL || op_q == OP_DIV) begin
						mag_q <= t1_q;
						den_q <= t2_q;
						neg_q <= sa_q ^ sb_q;
						gx_q  <= t1_q;
						gy_q  <= t2_q;
					end else begin
						den_q <= t3_q;
						gy_q  <= t3_q;
						if (sa_q == sb_q) begin
							mag_q <= t1_q + t2_q;
							gx_q  <= t1_q + t2_q;
							neg_q <= sa_q;
						end else if (t1_q >= t2_q) begin
							mag_q <= t1_q - t2_q;
							gx_q  <= t1_q - t2_q;
							neg_q <= sa_q;
						end else begin
							mag_q <= t2_q - t1_q;
							gx_q  <= t2_q - t1_q;
							neg_q <= sb_q;
						end
					end
				end
			end
			S_GSTR: if (gy_q == '0) g_q <= gx_q;
			S_GWT: if (dv_done) begin
				gx_q <= gy_q;
				gy_q <= dv_r;
			end
			S_D1W: if (dv_done) mag_q <= dv_q;
			S_D2W: if (dv_done) den_q <= dv_q;
			S_FIN: begin
				if (mag_q == '0) begin
					res_num <= '0;
					res_den <= (N-1)'(1);
					status  <= ST_OK;
				end else if (den_q > W'({(N-1){1'b1}}) ||
				             mag_q > (neg_q ? (W'(1) << (N-1)) : W'({(N-1){1'b1}}))) begin
					res_num <= '0;
					res_den <= '0;
					status  <= ST_OVF;
				end else begin
					res_num <= neg_q ? N'(-mag_q) : mag_q[N-1:0];
					res_den <= den_q[N-2:0];
					status  <= ST_OK;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	// A result is only shown in the output state.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_OUT) else $error("valid outside output state");
	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(res_num) && $stable(status))
		else $error("stalled result changed");
	// No item is taken while one is at work.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> in_stall) else $error("accepted while busy");
	// The sequencer does not leave the GCD wait for any state but the Euclid start.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_GWT && !dv_done |=> state_q == S_GWT || state_q == S_GSTR)
		else $error("sequencer left GCD wait early");
`endif

endmodule

>>> tb/tb_rational_arith_unit_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit core testbench
// Drives directed and random fraction items through the core under several
// idle and stall patterns and checks every result item against a predictor.
// ----------------------------------------------------------------------------
module tb_rational_arith_unit_core;
	import rau_pkg::*;

	localparam int FB = 16;
	localparam int N_RANDOM = 1130;

	typedef struct packed {
		logic [2:0]    op;
		logic [FB-1:0] an;
		logic [FB-2:0] ad;
		logic [FB-1:0] bn;
		logic [FB-2:0] bd;
	} frac_item_t;

	typedef struct packed {
		logic [FB-1:0] num;
		logic [FB-2:0] den;
		logic          eq;
		logic [1:0]    st;
	} frac_result_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [2:0] opcode;
	logic [FB-1:0] a_num;
	logic [FB-2:0] a_den;
	logic [FB-1:0] b_num;
	logic [FB-2:0] b_den;
	logic out_valid;
	logic out_stall;
	logic [FB-1:0] res_num;
	logic [FB-2:0] res_den;
	logic is_equal;
	logic [1:0] status;

	frac_item_t pending_items[$];
	frac_result_t expected_results[$];
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_sender;
	bit in_taken;
	int error_count;

	rational_arith_unit_core #(.FIELD_BITS(FB)) DUT (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .a_num(a_num), .a_den(a_den), .b_num(b_num),
		.b_den(b_den), .out_valid(out_valid), .out_stall(out_stall),
		.res_num(res_num), .res_den(res_den), .is_equal(is_equal), .status(status)
	);

	// Clock and reset.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
		longint unsigned r;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		return x;
	endfunction

	// Exact fraction arithmetic on 64-bit magnitudes, then reduction and range check.
	function automatic frac_result_t predict_fraction(frac_item_t it);
		frac_result_t r;
		longint signed an, bn;
		longint unsigned am, bm, ad, bd, t1, t2, mag, den, g, lim;
		bit sa, sb, neg;
		r = '0;
		an = longint'($signed(it.an));
		bn = longint'($signed(it.bn));
		ad = 64'(it.ad);
		bd = 64'(it.bd);
		sa = an < 0;
		sb = bn < 0;
		am = sa ? -an : an;
		bm = sb ? -bn : bn;
		if (it.op > OP_CMP || ad == 0 || bd == 0) begin
			r.st = ST_ERR;
			return r;
		end
		if (it.op == OP_CMP) begin
			r.den = (FB-1)'(1);
			r.eq = (an * longint'(bd)) == (bn * longint'(ad));
			return r;
		end
		case (it.op)
			OP_ADD, OP_SUB: begin
				t1 = am * bd;
				t2 = bm * ad;
				if (it.op == OP_SUB && bm != 0) sb = !sb;
				if (sa == sb) begin
					mag = t1 + t2;
					neg = sa;
				end else if (t1 >= t2) begin
					mag = t1 - t2;
					neg = sa;
				end else begin
					mag = t2 - t1;
					neg = sb;
				end
				den = ad * bd;
			end
			OP_MUL: begin
				mag = am * bm;
				den = ad * bd;
				neg = sa != sb;
			end
			default: begin
				if (bm == 0) begin
					r.st = ST_ERR;
					return r;
				end
				mag = am * bd;
				den = ad * bm;
				neg = sa != sb;
			end
		endcase
		if (mag == 0) begin
			r.den = (FB-1)'(1);
			return r;
		end
		g = gcd_of(mag, den);
		mag = mag / g;
		den = den / g;
		lim = neg ? (64'd1 << (FB - 1)) : ((64'd1 << (FB - 1)) - 1);
		if (den > ((64'd1 << (FB - 1)) - 1) || mag > lim) begin
			r.st = ST_OVF;
			return r;
		end
		r.num = FB'(neg ? -mag : mag);
		r.den = (FB-1)'(den);
		return r;
	endfunction

	// Input acceptance seen at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) in_taken <= 1'b0;
		else in_taken <= in_valid && !in_stall;
	end

	// Driver: offers the next pending item, with random idle cycles.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			{opcode, a_num, a_den, b_num, b_den} <= '0;
		end else if (!in_valid || in_taken) begin
			if (pending_items.size() > 0 && !hold_sender &&
				$urandom_range(99) >= send_idle_pct) begin
				frac_item_t it;
				it = pending_items.pop_front();
				expected_results.push_back(predict_fraction(it));
				in_valid <= 1'b1;
				{opcode, a_num, a_den, b_num, b_den} <= it;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall pattern.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) out_stall <= 1'b0;
		else out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Monitor: compares each accepted result item with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			frac_result_t exp_r;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result num=%0d den=%0d eq=%0d st=%0d",
					$time, $signed(res_num), res_den, is_equal, status);
				error_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (exp_r.num !== res_num || exp_r.den !== res_den ||
					exp_r.eq !== is_equal || exp_r.st !== status) begin
					$display({"%0t: mismatch expected num=%0d den=%0d eq=%0d st=%0d,",
						" actual num=%0d den=%0d eq=%0d st=%0d"},
						$time, $signed(exp_r.num), exp_r.den, exp_r.eq, exp_r.st,
						$signed(res_num), res_den, is_equal, status);
					error_count++;
				end
			end
		end
	end

	function automatic frac_item_t make_item(logic [2:0] op, int an, int ad, int bn, int bd);
		frac_item_t it;
		it.op = op;
		it.an = an[FB-1:0];
		it.ad = ad[FB-2:0];
		it.bn = bn[FB-1:0];
		it.bd = bd[FB-2:0];
		return it;
	endfunction

	// Random operand: small fractions in 45 percent of items so reductions and equalities occur.
	function automatic frac_item_t random_item();
		frac_item_t it;
		int sel;
		it.op = ($urandom_range(99) < 4) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
		sel = $urandom_range(99);
		if (sel < 45) begin
			it.an = FB'($signed($urandom_range(0, 40)) - 20);
			it.ad = (FB-1)'($urandom_range(1, 24));
			it.bn = FB'($signed($urandom_range(0, 40)) - 20);
			it.bd = (FB-1)'($urandom_range(1, 24));
			if (it.op == OP_CMP && $urandom_range(1)) begin
				it.bn = FB'($signed(it.an) * 3);
				it.bd = (FB-1)'(it.ad * 3);
			end
		end else begin
			it.an = FB'($urandom());
			it.ad = (FB-1)'($urandom());
			it.bn = FB'($urandom());
			it.bd = (FB-1)'($urandom());
		end
		if ($urandom_range(99) < 3) it.ad = '0;
		if ($urandom_range(99) < 3) it.bd = '0;
		if ($urandom_range(99) < 4) it.bn = '0;
		return it;
	endfunction

	task automatic wait_drained();
		while (pending_items.size() > 0 || expected_results.size() > 0 || in_valid)
			@(posedge clk);
	endtask

	// Stimulus: directed cases, then random phases with varying idling and stalling.
	initial begin
		error_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_sender = 1'b0;
		@(posedge arst_n);
		pending_items.push_back(make_item(OP_ADD, 1, 2, 1, 3));
		pending_items.push_back(make_item(OP_SUB, 1, 2, 1, 2));
		pending_items.push_back(make_item(OP_SUB, 0, 5, 0, 7));
		pending_items.push_back(make_item(OP_MUL, -32768, 1, -1, 1));
		pending_items.push_back(make_item(OP_MUL, -32768, 1, 1, 1));
		pending_items.push_back(make_item(OP_ADD, 32767, 1, 32767, 1));
		pending_items.push_back(make_item(OP_ADD, -32768, 32767, 32767, 32767));
		pending_items.push_back(make_item(OP_DIV, 3, 4, 0, 5));
		pending_items.push_back(make_item(OP_DIV, -7, 3, -14, 6));
		pending_items.push_back(make_item(OP_DIV, 1, 32767, 32767, 1));
		pending_items.push_back(make_item(OP_MUL, 1, 32767, 1, 32767));
		pending_items.push_back(make_item(OP_CMP, 1, 2, 2, 4));
		pending_items.push_back(make_item(OP_CMP, 1, 2, -1, 2));
		pending_items.push_back(make_item(OP_CMP, 0, 1, 0, 9));
		pending_items.push_back(make_item(OP_CMP, 1, 0, 1, 1));
		pending_items.push_back(make_item(OP_ADD, 1, 1, 1, 0));
		pending_items.push_back(make_item(3'd5, 1, 1, 1, 1));
		pending_items.push_back(make_item(3'd6, -1, 1, 1, 1));
		pending_items.push_back(make_item(3'd7, 1, 1, 1, 1));
		pending_items.push_back(make_item(OP_SUB, -32768, 32767, 32767, 32767));
		wait_drained();

		// Sender holds off while ten random items are queued, then is released.
		hold_sender = 1'b1;
		for (int i = 0; i < 10; i++) pending_items.push_back(random_item());
		repeat (50) @(posedge clk);
		hold_sender = 1'b0;
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 68; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 68; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			for (int i = 0; i < N_RANDOM / 4; i++) pending_items.push_back(random_item());
			wait_drained();
		end
		repeat (200) @(posedge clk);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog: ends the run as failed if it has not finished.
	initial begin
		#40000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> sim.f
sv/rau_pkg.sv
sv/rau_divider.sv
sv/rational_arith_unit_core.sv
tb/tb_rational_arith_unit_core.sv
